// ----- sv/dbl_pkg.sv -----
// Shared types and constants for the depth book level table.
// No dependencies; every other file imports this package.
package dbl_pkg;

    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int ID_W    = 48;

    // Operation carried by an input item.
    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    // Side carried by an input item.
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // Command broadcast to every cell of one side chain.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [PRICE_W-1:0] key;
    } dbl_cmd_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic               valid;
        logic               place;
        logic [PRICE_W-1:0] key;
    } dbl_link_t;

    // Buffered level of the pending store.
    typedef struct packed {
        logic               side;
        logic               qty_nz;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    uid;
    } dbl_pend_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_REPLAY
    } dbl_state_t;

endpackage

// ----- sv/dbl_cell.sv -----
// One cell of a sorted price chain: holds one key and a valid bit.
// Depends on dbl_pkg.
module dbl_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  dbl_pkg::dbl_cmd_t cmd,
    input  logic              any_hit,
    input  dbl_pkg::dbl_link_t prev_link,
    input  dbl_pkg::dbl_link_t next_link,
    output dbl_pkg::dbl_link_t link,
    output logic              hit
);
    import dbl_pkg::*;

    logic               valid_reg, valid_next;
    logic [PRICE_W-1:0] key_reg, key_next;
    logic               place;

    // The new key goes at the first cell that is empty or holds a larger key.
    assign place = !valid_reg || (key_reg > cmd.key);
    assign hit   = valid_reg && (key_reg == cmd.key);
    assign link  = '{valid: valid_reg, place: place, key: key_reg};

    // Insert shifts the tail right; erase shifts it left.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (cmd.ins && !any_hit && place)
        begin
            if (prev_link.place)
            begin
                valid_next = prev_link.valid;
                key_next   = prev_link.key;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = cmd.key;
            end
        end
        else if (cmd.del && any_hit && valid_reg && (key_reg >= cmd.key))
        begin
            valid_next = next_link.valid;
            key_next   = next_link.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ----- sv/dbl_chain.sv -----
// Row of cells keeping one side's prices sorted, best at cell zero.
// Depends on dbl_pkg and dbl_cell.
module dbl_chain #(
    parameter int LEVELS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dbl_pkg::dbl_cmd_t          cmd,
    output logic                       head_valid,
    output logic [dbl_pkg::PRICE_W-1:0] head_key,
    output logic                       overflow
);
    import dbl_pkg::*;

    dbl_link_t         links [LEVELS];
    logic [LEVELS-1:0] hits;
    logic              any_hit;
    logic              full;
    dbl_cmd_t          cell_cmd;

    assign any_hit  = |hits;
    assign full     = links[LEVELS-1].valid;
    assign overflow = cmd.ins && !any_hit && full;

    // A full chain takes no new price.
    always_comb
    begin
        cell_cmd     = cmd;
        cell_cmd.ins = cmd.ins && !full;
    end

    // Cells with their neighbor links; the ends see an empty neighbor.
    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        dbl_link_t prev_l, next_l;
        if (i == 0)
            assign prev_l = '{valid: 1'b0, place: 1'b0, key: '0};
        else
            assign prev_l = links[i-1];
        if (i == LEVELS-1)
            assign next_l = '{valid: 1'b0, place: 1'b1, key: '0};
        else
            assign next_l = links[i+1];
        dbl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cell_cmd),
            .any_hit  (any_hit),
            .prev_link(prev_l),
            .next_link(next_l),
            .link     (links[i]),
            .hit      (hits[i])
        );
    end

    assign head_valid = links[0].valid;
    assign head_key   = links[0].key;

    // Valid cells stay packed toward the head.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        links[1].valid |-> links[0].valid) else $error("chain has a gap");
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        links[1].valid |-> (links[1].key > links[0].key)) else $error("chain not sorted");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> $onehot(hits) || (hits == '0)) else $error("duplicate key");

endmodule

// ----- sv/depth_book_level_table.sv -----
// Top level of the depth book level table: pending store, replay sequencer, result stage.
// Depends on dbl_pkg and dbl_chain.
//
//  channel | handshake          | payload
//  input   | in_valid/in_stall  | op side price quantity update_id last_in_event
//  output  | out_valid/out_stall| best_bid best_ask spread_ticks mid_price flags
//
// An item is written into the side chains; an update that ends an event then goes to
// the result stage, which loads the output register when both sides hold a level.
// The final snapshot level starts a replay of the pending store, one entry a cycle
// from its read port, during which input stalls.
// Reset empties both chains, the pending store and all flags.
// Input also stalls while a result is pending and while the output register is stalled.
module depth_book_level_table #(
    parameter int LEVELS_PER_SIDE = 64,
    parameter int PENDING_DEPTH   = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic                        side,
    input  logic [dbl_pkg::PRICE_W-1:0] price,
    input  logic [dbl_pkg::QTY_W-1:0]   quantity,
    input  logic [dbl_pkg::ID_W-1:0]    update_id,
    input  logic                        last_in_event,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dbl_pkg::PRICE_W-1:0] best_bid,
    output logic [dbl_pkg::PRICE_W-1:0] best_ask,
    output logic signed [dbl_pkg::PRICE_W:0] spread_ticks,
    output logic [dbl_pkg::PRICE_W-1:0] mid_price,
    output logic                        level_overflow,
    output logic                        pending_overflow
);
    import dbl_pkg::*;

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    dbl_state_t         state_reg, state_next;
    logic               ready_reg, ready_next;
    logic [CW-1:0]      pcount_reg, pcount_next;
    logic [CW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic               rd_v_reg, rd_v_next;
    dbl_pend_t          rd_data_reg;
    logic [ID_W-1:0]    snap_uid_reg;
    logic               res_pend_reg, res_pend_next;
    logic               lvl_ovf_reg, lvl_ovf_next;
    logic               pnd_ovf_reg, pnd_ovf_next;
    logic               out_v_reg, out_v_next;
    logic [PRICE_W-1:0] bb_reg, ba_reg, mid_reg;
    logic signed [PRICE_W:0] spr_reg;

    dbl_pend_t          pend_mem [PENDING_DEPTH];

    logic               accept, rd_issue, load_out;
    logic               c_en, c_side, c_ins, c_del;
    logic [PRICE_W-1:0] c_price;
    dbl_cmd_t           bid_cmd, ask_cmd;
    logic               bid_hv, ask_hv, bid_ovf, ask_ovf;
    logic [PRICE_W-1:0] bid_hk, ask_hk, bb, ba;
    logic signed [PRICE_W:0] spr, half;

    assign in_stall = (state_reg != ST_IDLE) || res_pend_reg || (out_v_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign rd_issue = (state_reg == ST_REPLAY) && (rd_ptr_reg < pcount_reg);

    // Chain command from a replayed entry or from the accepted item.
    always_comb
    begin
        c_en = 1'b0; c_side = side; c_ins = 1'b0; c_del = 1'b0; c_price = price;
        if (rd_v_reg)
        begin
            c_side  = rd_data_reg.side;
            c_price = rd_data_reg.price;
            c_en    = rd_data_reg.uid > snap_uid_reg;
            c_ins   = rd_data_reg.qty_nz;
            c_del   = !rd_data_reg.qty_nz;
        end
        else if (accept && (op == OP_SNAPSHOT) && !ready_reg)
        begin
            c_en  = 1'b1;
            c_ins = 1'b1;
        end
        else if (accept && (op == OP_UPDATE) && ready_reg)
        begin
            c_en  = 1'b1;
            c_ins = quantity != '0;
            c_del = quantity == '0;
        end
    end

    // Bids are kept as inverted keys so both chains sort ascending.
    assign bid_cmd = '{ins: c_en && c_ins && (c_side == SIDE_BID),
                       del: c_en && c_del && (c_side == SIDE_BID), key: ~c_price};
    assign ask_cmd = '{ins: c_en && c_ins && (c_side == SIDE_ASK),
                       del: c_en && c_del && (c_side == SIDE_ASK), key: c_price};

    dbl_chain #(.LEVELS(LEVELS_PER_SIDE)) u_bid (
        .clk(clk), .rst_n(rst_n), .cmd(bid_cmd), .head_valid(bid_hv),
        .head_key(bid_hk), .overflow(bid_ovf)
    );
    dbl_chain #(.LEVELS(LEVELS_PER_SIDE)) u_ask (
        .clk(clk), .rst_n(rst_n), .cmd(ask_cmd), .head_valid(ask_hv),
        .head_key(ask_hk), .overflow(ask_ovf)
    );

    // Top of book and derived figures.
    assign bb   = ~bid_hk;
    assign ba   = ask_hk;
    assign spr  = $signed({1'b0, ba}) - $signed({1'b0, bb});
    assign half = (spr + $signed({{PRICE_W{1'b0}}, spr[PRICE_W]})) >>> 1;
    assign load_out = res_pend_reg && bid_hv && ask_hv && (!out_v_reg || !out_stall);

    // Sequencer, pending count, flags and output control.
    always_comb
    begin
        state_next    = state_reg;
        ready_next    = ready_reg;
        pcount_next   = pcount_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_v_next     = rd_issue;
        res_pend_next = res_pend_reg;
        lvl_ovf_next  = lvl_ovf_reg || bid_ovf || ask_ovf;
        pnd_ovf_next  = pnd_ovf_reg;
        out_v_next    = out_v_reg && out_stall;
        if (load_out)
            out_v_next = 1'b1;
        if (res_pend_reg && (!out_v_reg || !out_stall))
            res_pend_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_UPDATE) && !ready_reg)
                begin
                    if (pcount_reg >= CW'(PENDING_DEPTH))
                        pnd_ovf_next = 1'b1;
                    else
                        pcount_next = pcount_reg + 1'b1;
                end
                if (accept && (op == OP_UPDATE) && ready_reg && last_in_event)
                    res_pend_next = 1'b1;
                if (accept && (op == OP_SNAPSHOT) && !ready_reg && last_in_event)
                begin
                    rd_ptr_next = '0;
                    state_next  = ST_REPLAY;
                end
            end
            ST_REPLAY:
            begin
                if (rd_issue)
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                else if (!rd_v_reg)
                begin
                    ready_next  = 1'b1;
                    pcount_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ready_reg    <= 1'b0;
            pcount_reg   <= '0;
            rd_ptr_reg   <= '0;
            rd_v_reg     <= 1'b0;
            res_pend_reg <= 1'b0;
            lvl_ovf_reg  <= 1'b0;
            pnd_ovf_reg  <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            pcount_reg   <= pcount_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_v_reg     <= rd_v_next;
            res_pend_reg <= res_pend_next;
            lvl_ovf_reg  <= lvl_ovf_next;
            pnd_ovf_reg  <= pnd_ovf_next;
            out_v_reg    <= out_v_next;
        end
    end

    // Pending store: written at the fill count, read by the replay pointer.
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_UPDATE) && !ready_reg && (pcount_reg < CW'(PENDING_DEPTH)))
            pend_mem[pcount_reg[AW-1:0]] <= '{side: side, qty_nz: quantity != '0,
                                               price: price, uid: update_id};
        if (rd_issue)
            rd_data_reg <= pend_mem[rd_ptr_reg[AW-1:0]];
    end

    // Snapshot id and result payload.
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_SNAPSHOT) && !ready_reg && last_in_event)
            snap_uid_reg <= update_id;
        if (load_out)
        begin
            bb_reg  <= bb;
            ba_reg  <= ba;
            spr_reg <= spr;
            mid_reg <= bb + half[PRICE_W-1:0];
        end
    end

    assign out_valid        = out_v_reg;
    assign best_bid         = bb_reg;
    assign best_ask         = ba_reg;
    assign spread_ticks     = spr_reg;
    assign mid_price        = mid_reg;
    assign level_overflow   = lvl_ovf_reg;
    assign pending_overflow = pnd_ovf_reg;

    // The replay holds input off and never runs once the book is ready.
    a_replay_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLAY) |-> (in_stall && !ready_reg)) else $error("replay not held");
    a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= CW'(PENDING_DEPTH)) else $error("pending count beyond depth");
    a_res_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_pend_reg |-> ready_reg) else $error("result before sync");
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> (pcount_reg == '0)) else $error("pending not emptied");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for depth_book_level_table: directed items and table, then random depth traffic.
// Depends on dbl_pkg and the block's RTL; results are checked against a built-in book model.
module tb;
    import dbl_pkg::*;

    // One input item, with an optional typed top of book for directed rows.
    typedef struct {
        logic               op;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    uid;
        logic               last;
        bit                 chk;
        logic [PRICE_W-1:0] exp_bid;
        logic [PRICE_W-1:0] exp_ask;
    } level_item_t;

    // One top-of-book report.
    typedef struct {
        logic [PRICE_W-1:0]      bb;
        logic [PRICE_W-1:0]      ba;
        logic signed [PRICE_W:0] spread;
        logic [PRICE_W-1:0]      mid;
        logic                    lvl_ovf;
        logic                    pend_ovf;
    } top_of_book_t;

    localparam int LEVELS = 64;
    localparam int PDEPTH = 256;
    localparam logic [ID_W-1:0] SNAP_ID = 48'd1000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    op;
    logic                    side;
    logic [PRICE_W-1:0]      price;
    logic [QTY_W-1:0]        quantity;
    logic [ID_W-1:0]         update_id;
    logic                    last_in_event;
    logic                    out_valid;
    logic                    out_stall;
    logic [PRICE_W-1:0]      best_bid;
    logic [PRICE_W-1:0]      best_ask;
    logic signed [PRICE_W:0] spread_ticks;
    logic [PRICE_W-1:0]      mid_price;
    logic                    level_overflow;
    logic                    pending_overflow;

    // Model state of the book.
    logic [PRICE_W-1:0] book_px [2][LEVELS];
    int                 book_cnt [2];
    logic [PRICE_W-1:0] pend_px [PDEPTH];
    logic               pend_nz [PDEPTH];
    logic               pend_side [PDEPTH];
    logic [ID_W-1:0]    pend_id [PDEPTH];
    int                 pend_cnt;
    bit                 synced;
    bit                 lvl_ovf_m;
    bit                 pend_ovf_m;

    top_of_book_t tob_queue [$];
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;

    level_item_t  directed [$];

    depth_book_level_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .side(side), .price(price), .quantity(quantity),
        .update_id(update_id), .last_in_event(last_in_event),
        .out_valid(out_valid), .out_stall(out_stall),
        .best_bid(best_bid), .best_ask(best_ask), .spread_ticks(spread_ticks),
        .mid_price(mid_price), .level_overflow(level_overflow),
        .pending_overflow(pending_overflow)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Insert a price on one side unless present; a full side sets the level overflow flag.
    function automatic void book_put(logic s, logic [PRICE_W-1:0] p);
        for (int i = 0; i < book_cnt[s]; i++)
            if (book_px[s][i] == p)
                return;
        if (book_cnt[s] >= LEVELS)
        begin
            lvl_ovf_m = 1'b1;
            return;
        end
        book_px[s][book_cnt[s]] = p;
        book_cnt[s]++;
    endfunction

    // Erase a price, moving the last entry into its slot.
    function automatic void book_erase(logic s, logic [PRICE_W-1:0] p);
        for (int i = 0; i < book_cnt[s]; i++)
            if (book_px[s][i] == p)
            begin
                book_px[s][i] = book_px[s][book_cnt[s]-1];
                book_cnt[s]--;
                return;
            end
    endfunction

    function automatic void book_apply(logic s, logic [PRICE_W-1:0] p, bit nz);
        if (nz)
            book_put(s, p);
        else
            book_erase(s, p);
    endfunction

    // Advance the book by one accepted item; returns 1 with the report when one is due.
    function automatic bit book_step(level_item_t it, output top_of_book_t r);
        longint sp;
        r = '{default: '0};
        if (it.op == OP_SNAPSHOT)
        begin
            if (synced)
                return 0;
            book_put(it.side, it.price);
            if (it.last)
            begin
                for (int i = 0; i < pend_cnt; i++)
                    if (pend_id[i] > it.uid)
                        book_apply(pend_side[i], pend_px[i], pend_nz[i]);
                pend_cnt = 0;
                synced = 1;
            end
            return 0;
        end
        if (!synced)
        begin
            if (pend_cnt >= PDEPTH)
                pend_ovf_m = 1'b1;
            else
            begin
                pend_px[pend_cnt] = it.price;
                pend_nz[pend_cnt] = (it.qty != 0);
                pend_side[pend_cnt] = it.side;
                pend_id[pend_cnt] = it.uid;
                pend_cnt++;
            end
            return 0;
        end
        book_apply(it.side, it.price, it.qty != 0);
        if (!it.last || book_cnt[SIDE_BID] == 0 || book_cnt[SIDE_ASK] == 0)
            return 0;
        r.bb = book_px[SIDE_BID][0];
        for (int i = 1; i < book_cnt[SIDE_BID]; i++)
            if (book_px[SIDE_BID][i] > r.bb)
                r.bb = book_px[SIDE_BID][i];
        r.ba = book_px[SIDE_ASK][0];
        for (int i = 1; i < book_cnt[SIDE_ASK]; i++)
            if (book_px[SIDE_ASK][i] < r.ba)
                r.ba = book_px[SIDE_ASK][i];
        sp = longint'(r.ba) - longint'(r.bb);
        r.spread = sp[PRICE_W:0];
        r.mid = PRICE_W'(longint'(r.bb) + sp / 2);
        r.lvl_ovf = lvl_ovf_m;
        r.pend_ovf = pend_ovf_m;
        return 1;
    endfunction

    // Drive one item, wait for acceptance, then record what it should cause.
    task automatic send_level(level_item_t it);
        top_of_book_t r;
        bit           due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= it.op;
        side          <= it.side;
        price         <= it.price;
        quantity      <= it.qty;
        update_id     <= it.uid;
        last_in_event <= it.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        due = book_step(it, r);
        if (due)
            tob_queue.insert(tob_queue.size(), r);
        if (it.chk && (!due || r.bb != it.exp_bid || r.ba != it.exp_ask))
        begin
            $display({"%0t: directed top of book expected bid %0d ask %0d,",
                      " model due %0b bid %0d ask %0d"},
                $time, it.exp_bid, it.exp_ask, due, r.bb, r.ba);
            errors++;
        end
    endtask

    function automatic level_item_t mk(logic o, logic s, logic [PRICE_W-1:0] p,
                                       logic [QTY_W-1:0] q, logic [ID_W-1:0] u, logic l,
                                       bit c, logic [PRICE_W-1:0] eb, logic [PRICE_W-1:0] ea);
        level_item_t it;
        it = '{o, s, p, q, u, l, c, eb, ea};
        return it;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(level_item_t it);
        directed.insert(directed.size(), it);
    endfunction

    // Random item, mostly updates: prices from a small pool per side, sometimes anywhere.
    function automatic level_item_t rand_level(int erase_pct, int pool);
        level_item_t it;
        it.op   = ($urandom_range(19) == 0) ? OP_SNAPSHOT : OP_UPDATE;
        it.side = 1'($urandom_range(1));
        if ($urandom_range(15) == 0)
            it.price = $urandom;
        else if (it.side == SIDE_BID)
            it.price = 10000 + $urandom_range(pool - 1);
        else
            it.price = 10000 + pool / 2 + $urandom_range(pool - 1);
        it.qty  = ($urandom_range(99) < erase_pct) ? '0 : $urandom;
        it.uid  = ID_W'({$urandom, $urandom});
        it.last = ($urandom_range(2) == 0);
        it.chk  = 0;
        it.exp_bid = '0;
        it.exp_ask = '0;
        return it;
    endfunction

    // Result checking and output stall.
    always @(posedge clk or negedge rst_n)
    begin
        top_of_book_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tob_queue.size() == 0)
                begin
                    $display("%0t: unexpected result bid %0d ask %0d", $time, best_bid, best_ask);
                    errors++;
                end
                else
                begin
                    e = tob_queue.pop_front();
                    if (best_bid !== e.bb)
                    begin
                        $display("%0t: best_bid expected %0d actual %0d", $time, e.bb, best_bid);
                        errors++;
                    end
                    if (best_ask !== e.ba)
                    begin
                        $display("%0t: best_ask expected %0d actual %0d", $time, e.ba, best_ask);
                        errors++;
                    end
                    if (spread_ticks !== e.spread)
                    begin
                        $display("%0t: spread_ticks expected %0d actual %0d",
                            $time, e.spread, spread_ticks);
                        errors++;
                    end
                    if (mid_price !== e.mid)
                    begin
                        $display("%0t: mid_price expected %0d actual %0d", $time, e.mid, mid_price);
                        errors++;
                    end
                    if (level_overflow !== e.lvl_ovf)
                    begin
                        $display("%0t: level_overflow expected %0b actual %0b",
                            $time, e.lvl_ovf, level_overflow);
                        errors++;
                    end
                    if (pending_overflow !== e.pend_ovf)
                    begin
                        $display("%0t: pending_overflow expected %0b actual %0b",
                            $time, e.pend_ovf, pending_overflow);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog.
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus.
    initial
    begin
        level_item_t it;
        int          n;
        errors = 0;
        send_idle_pct = 15;
        recv_idle_pct = 64;
        book_cnt[0] = 0;
        book_cnt[1] = 0;
        pend_cnt = 0;
        synced = 0;
        lvl_ovf_m = 0;
        pend_ovf_m = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_UPDATE;
        side = SIDE_BID;
        price = '0;
        quantity = '0;
        update_id = '0;
        last_in_event = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Updates before sync are only buffered; the newer one is replayed later.
        send_level(mk(OP_UPDATE, SIDE_BID, 500, 5, SNAP_ID + 1, 1, 0, 0, 0));
        send_level(mk(OP_UPDATE, SIDE_ASK, 600, 0, SNAP_ID - 1, 1, 0, 0, 0));

        // Overfill the pending buffer, keeping replayed levels away from the top of book.
        for (int i = 0; i < PDEPTH + 4; i++)
        begin
            it = rand_level(20, 100);
            it.op = OP_UPDATE;
            it.price = (it.side == SIDE_BID) ? 100 + $urandom_range(200)
                                             : 800 + $urandom_range(200);
            it.uid = ($urandom_range(7) == 0) ? ID_W'(SNAP_ID + $urandom_range(1, 50))
                                              : ID_W'($urandom_range(32'(SNAP_ID)));
            send_level(it);
        end

        // Snapshot with a zero quantity level, a top price, and the final level.
        add_row(mk(OP_SNAPSHOT, SIDE_BID, 400, 0, SNAP_ID, 0, 0, 0, 0));
        add_row(mk(OP_SNAPSHOT, SIDE_ASK, 32'hFFFF_FFFF, 7, SNAP_ID, 0, 0, 0, 0));
        add_row(mk(OP_SNAPSHOT, SIDE_ASK, 700, 3, SNAP_ID, 1, 0, 0, 0));
        // Synced updates: insert, erase, erase of an absent price, ignored snapshot.
        add_row(mk(OP_UPDATE, SIDE_BID, 550, 1, 2000, 1, 1, 550, 700));
        add_row(mk(OP_UPDATE, SIDE_ASK, 32'hFFFF_FFFF, 0, 2001, 1, 1, 550, 700));
        add_row(mk(OP_UPDATE, SIDE_BID, 12345, 0, 2002, 1, 1, 550, 700));
        add_row(mk(OP_SNAPSHOT, SIDE_BID, 9999, 4, 2003, 1, 0, 0, 0));
        // Crossed book, then uncrossed without a report.
        add_row(mk(OP_UPDATE, SIDE_ASK, 500, 4, 2004, 1, 1, 550, 500));
        add_row(mk(OP_UPDATE, SIDE_ASK, 500, 0, 2005, 0, 0, 0, 0));
        // Price extremes on the bid side, then on the ask side.
        add_row(mk(OP_UPDATE, SIDE_BID, 32'hFFFF_FFFF, 9, 2006, 1, 1,
                   32'hFFFF_FFFF, 700));
        add_row(mk(OP_UPDATE, SIDE_BID, 32'hFFFF_FFFF, 0, 2007, 1, 1, 550, 700));
        add_row(mk(OP_UPDATE, SIDE_BID, 0, 2, 48'hFFFF_FFFF_FFFF, 1, 1, 550, 700));
        add_row(mk(OP_UPDATE, SIDE_ASK, 0, 32'hFFFF_FFFF, 0, 1, 1, 550, 0));
        add_row(mk(OP_UPDATE, SIDE_ASK, 0, 0, 1, 1, 1, 550, 700));
        foreach (directed[i])
            send_level(directed[i]);

        // Hold off until the book has reported everything.
        in_valid <= 1'b0;
        while (tob_queue.size() != 0)
            @(posedge clk);

        // Random traffic in three idling phases, with varying erase rates and pool sizes.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 15 : 0;
            n = 0;
            while (n < 375)
            begin
                case ((n / 80) % 3)
                    0: it = rand_level(10, 150);
                    1: it = rand_level(70, 60);
                    default: it = rand_level(35, 90);
                endcase
                send_level(it);
                n++;
            end
        end
        in_valid <= 1'b0;

        while (tob_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
sv/dbl_pkg.sv
sv/dbl_cell.sv
sv/dbl_chain.sv
sv/depth_book_level_table.sv
test/tb.sv
